// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command encodings and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_STOP   = 8;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int MODE_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int ATTR_W  = 8;
	localparam int CELL_W  = CHAR_W + ATTR_W;
	localparam int ADDR_W  = 11;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int PTR_W   = $clog2(CELL_COUNT);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_PUT   = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(2);

	localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

	localparam logic [CELL_W-1:0] RESET_CELL       = 16'h0F20;
	localparam logic [ATTR_W-1:0] RESET_BLANK_ATTR = 8'h0F;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_BACKSPACE,
		OP_TAB,
		OP_CR,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CELL_W-1:0] cell_word;
		logic [ADDR_W-1:0] addr;
		logic              addr_ok;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_slot_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              copy;
		logic [PTR_W-1:0]  addr;
		logic [CELL_W-1:0] data;
	} wr_t;

endpackage

// ===== hw/rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine: 80x25 screen of character/attribute cells with a
// cursor, fed by put, clear and read commands.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. Commands other than clear that need
// no scroll pass from the idle state straight to the done state of the
// execution state machine. A put or tab that runs past the last row scrolls
// the screen through the screen memory, which has one read and one write port:
// one cell copied per cycle for all rows but the first, then the bottom row is
// blanked. Clear writes every cell once. After reset the screen memory is
// filled with blank cells and the first command starts only once the last fill
// write has landed; until then requests queue but are not executed.
// Configuration writes are taken at any time and cfg_ready is always high.
module text_console_writer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [tcw_pkg::MODE_W-1:0]   mode,
	input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]  bg_color,
	input  logic [tcw_pkg::COLOR_W-1:0]  fg_color,
	input  logic [tcw_pkg::ADDR_W-1:0]   cell_address,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [tcw_pkg::COL_W-1:0]    cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]   cursor_linear,
	output logic [tcw_pkg::CHAR_W-1:0]   cell_char,
	output logic [tcw_pkg::ATTR_W-1:0]   cell_attr,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]   blank_attribute
);

	tcw_pkg::cmd_slot_t push;
	tcw_pkg::cmd_slot_t head;
	logic               q_full;
	logic               pop;

	assign cfg_ready = 1'b1;

	tcw_front u_front (
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.mode         (mode),
		.char_code    (char_code),
		.bg_color     (bg_color),
		.fg_color     (fg_color),
		.cell_address (cell_address),
		.q_full       (q_full),
		.push         (push)
	);

	tcw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	tcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid & cfg_ready),
		.cfg_data      (blank_attribute),
		.head          (head),
		.pop           (pop),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.cursor_linear (cursor_linear),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr)
	);

endmodule

// ===== hw/rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request transactions and decodes them into console commands.
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [tcw_pkg::MODE_W-1:0]    mode,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]   bg_color,
	input  logic [tcw_pkg::COLOR_W-1:0]   fg_color,
	input  logic [tcw_pkg::ADDR_W-1:0]    cell_address,
	input  logic                          q_full,
	output tcw_pkg::cmd_slot_t            push
);

	tcw_pkg::op_t put_op;
	tcw_pkg::op_t op;

	always_comb begin
		priority if (char_code == tcw_pkg::CHAR_BACKSPACE) begin
			put_op = tcw_pkg::OP_BACKSPACE;
		end else if (char_code == tcw_pkg::CHAR_TAB) begin
			put_op = tcw_pkg::OP_TAB;
		end else if (char_code == tcw_pkg::CHAR_CR) begin
			put_op = tcw_pkg::OP_CR;
		end else if (char_code >= tcw_pkg::CHAR_SPACE) begin
			put_op = tcw_pkg::OP_PUT;
		end else begin
			put_op = tcw_pkg::OP_NOP;
		end
	end

	always_comb begin
		unique case (mode)
			tcw_pkg::MODE_PUT:   op = put_op;
			tcw_pkg::MODE_CLEAR: op = tcw_pkg::OP_CLEAR;
			tcw_pkg::MODE_READ:  op = tcw_pkg::OP_READ;
			default:             op = tcw_pkg::OP_NOP;
		endcase
	end

	assign req_stall          = q_full;
	assign push.valid         = req_valid & ~q_full;
	assign push.cmd.op        = op;
	assign push.cmd.cell_word = {bg_color, fg_color, char_code};
	assign push.cmd.addr      = cell_address;
	assign push.cmd.addr_ok   = (cell_address < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT));

endmodule

// ===== hw/rtl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module tcw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::cmd_slot_t push,
	output logic               full,
	output tcw_pkg::cmd_slot_t head,
	input  logic               pop
);

	tcw_pkg::cmd_t                 slot_q [tcw_pkg::QUEUE_DEPTH];
	logic [tcw_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tcw_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full     = (count_q == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
	assign do_push  = push.valid & ~full;
	assign do_pop   = pop & (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executes console commands on the screen memory and cursor, and holds the
// result register.
// ----------------------------------------------------------------------------
module tcw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data,
	input  tcw_pkg::cmd_slot_t           head,
	output logic                         pop,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [tcw_pkg::COL_W-1:0]    cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]   cursor_linear,
	output logic [tcw_pkg::CHAR_W-1:0]   cell_char,
	output logic [tcw_pkg::ATTR_W-1:0]   cell_attr
);

	localparam logic [tcw_pkg::PTR_W-1:0] LAST_PTR = tcw_pkg::PTR_W'(tcw_pkg::CELL_COUNT - 1);

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
	logic [tcw_pkg::CELL_W-1:0] rd_data_q;

	tcw_pkg::state_t             state_q, state_d;
	logic [tcw_pkg::PTR_W-1:0]   ptr_q, ptr_start;
	logic [tcw_pkg::COL_W-1:0]   col_q, col_d;
	logic [tcw_pkg::ROW_W-1:0]   row_q, row_d;
	logic [tcw_pkg::ATTR_W-1:0]  blank_attr_q;
	logic                        res_read_q;
	tcw_pkg::wr_t                wr_s1, wr_next;

	logic                        head_go;
	logic                        rd_en;
	logic [tcw_pkg::PTR_W-1:0]   rd_addr;
	logic                        scroll_need;
	logic                        ptr_last;
	logic                        rsp_free;
	logic [tcw_pkg::ADDR_W-1:0]  cur_lin;
	logic [tcw_pkg::ADDR_W-1:0]  row_ext;
	logic [tcw_pkg::COL_W:0]     col_ext, ncol;
	logic [tcw_pkg::ROW_W:0]     nrow;
	logic [tcw_pkg::CELL_W-1:0]  blank_cell;

	logic                        rsp_valid_q;
	logic [tcw_pkg::COL_W-1:0]   rsp_col_q;
	logic [tcw_pkg::ROW_W-1:0]   rsp_row_q;
	logic [tcw_pkg::ADDR_W-1:0]  rsp_lin_q;
	logic [tcw_pkg::CELL_W-1:0]  rsp_cell_q;

	assign blank_cell = {blank_attr_q, tcw_pkg::CHAR_SPACE};
	assign row_ext    = tcw_pkg::ADDR_W'(row_q);
	assign cur_lin    = tcw_pkg::ADDR_W'(row_ext * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS))
		+ tcw_pkg::ADDR_W'(col_q);
	assign ptr_last   = (ptr_q == LAST_PTR);
	assign rsp_free   = ~rsp_valid_q | ~rsp_stall;
	assign col_ext    = {1'b0, col_q};
	// the last fill write must land before a command may read the memory
	assign head_go    = head.valid & ~wr_s1.valid;

	// cursor movement for the command at the queue head
	always_comb begin
		unique case (head.cmd.op)
			tcw_pkg::OP_PUT:       ncol = col_ext + 1'b1;
			tcw_pkg::OP_BACKSPACE: ncol = (col_q != '0) ? col_ext - 1'b1 : col_ext;
			tcw_pkg::OP_TAB:       ncol = col_ext + (tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_STOP)
				- (tcw_pkg::COL_W + 1)'(col_ext % tcw_pkg::TAB_STOP);
			tcw_pkg::OP_CR:        ncol = '0;
			tcw_pkg::OP_CLEAR:     ncol = '0;
			default:               ncol = col_ext;
		endcase
		nrow        = {1'b0, row_q};
		scroll_need = 1'b0;
		if (head.cmd.op == tcw_pkg::OP_CLEAR) begin
			nrow = '0;
		end else if (ncol >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) begin
			ncol = '0;
			nrow = nrow + 1'b1;
			if (nrow >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) begin
				nrow        = (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS - 1);
				scroll_need = 1'b1;
			end
		end
		col_d = ncol[tcw_pkg::COL_W-1:0];
		row_d = nrow[tcw_pkg::ROW_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (ptr_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (head_go) begin
					if (head.cmd.op == tcw_pkg::OP_CLEAR) begin
						state_d = tcw_pkg::ST_CLEAR;
					end else if (scroll_need) begin
						state_d = tcw_pkg::ST_SCROLL;
					end else begin
						state_d = tcw_pkg::ST_DONE;
					end
				end
			end
			tcw_pkg::ST_SCROLL: begin
				if (ptr_last) state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				if (ptr_last) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_CLEAR: begin
				if (ptr_last) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE: begin
				if (rsp_free) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_next = '0;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				wr_next = '{valid: 1'b1, copy: 1'b0, addr: ptr_q, data: tcw_pkg::RESET_CELL};
			end
			tcw_pkg::ST_IDLE: begin
				pop = head_go;
				if (head_go && head.cmd.op == tcw_pkg::OP_READ && head.cmd.addr_ok) begin
					rd_en   = 1'b1;
					rd_addr = tcw_pkg::PTR_W'(head.cmd.addr);
				end
				if (head_go && head.cmd.op == tcw_pkg::OP_PUT) begin
					wr_next = '{valid: 1'b1, copy: 1'b0, addr: tcw_pkg::PTR_W'(cur_lin),
						data: head.cmd.cell_word};
				end
			end
			tcw_pkg::ST_SCROLL: begin
				rd_en   = 1'b1;
				wr_next = '{valid: 1'b1, copy: 1'b1,
					addr: ptr_q - tcw_pkg::PTR_W'(tcw_pkg::COLUMNS), data: '0};
			end
			tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
				wr_next = '{valid: 1'b1, copy: 1'b0, addr: ptr_q, data: blank_cell};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (state_d)
			tcw_pkg::ST_SCROLL: ptr_start = tcw_pkg::PTR_W'(tcw_pkg::COLUMNS);
			tcw_pkg::ST_BLANK:  ptr_start = tcw_pkg::PTR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
			default:            ptr_start = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_s1.valid) begin
			mem[wr_s1.addr] <= wr_s1.copy ? rd_data_q : wr_s1.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcw_pkg::ST_INIT;
			ptr_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			blank_attr_q <= tcw_pkg::RESET_BLANK_ATTR;
			res_read_q   <= 1'b0;
			wr_s1        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= (state_d != state_q) ? ptr_start : ptr_q + 1'b1;
			wr_s1   <= wr_next;
			if (cfg_valid) begin
				blank_attr_q <= cfg_data;
			end
			if (pop) begin
				col_q      <= col_d;
				row_q      <= row_d;
				res_read_q <= (head.cmd.op == tcw_pkg::OP_READ) & head.cmd.addr_ok;
			end
			if (state_q == tcw_pkg::ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcw_pkg::ST_DONE && rsp_free) begin
			rsp_col_q  <= col_q;
			rsp_row_q  <= row_q;
			rsp_lin_q  <= cur_lin;
			rsp_cell_q <= res_read_q ? rd_data_q : '0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign cursor_column = rsp_col_q;
	assign cursor_row    = rsp_row_q;
	assign cursor_linear = rsp_lin_q;
	assign cell_char     = rsp_cell_q[tcw_pkg::CHAR_W-1:0];
	assign cell_attr     = rsp_cell_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) && (row_q < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
		else $error("cursor outside the screen");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == tcw_pkg::ST_DONE))
		else $error("result raised outside completion");

	a_scroll_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_SCROLL) |-> (ptr_q >= tcw_pkg::PTR_W'(tcw_pkg::COLUMNS)))
		else $error("scroll source pointer below second row");

	a_copy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_s1.valid && wr_s1.copy) |-> $past(state_q == tcw_pkg::ST_SCROLL && rd_en))
		else $error("copy write without a preceding scroll read");

endmodule
